// ===== rtl/core/cer_pkg.sv =====
// Shared types and constants for the counter extend and rate estimator.
// Used by every module under rtl/core except cer_divider; depends on nothing.
package cer_pkg;

  localparam int unsigned SCALE_SHIFT = 13;

  localparam logic [63:0] StartCounterReset  = 64'd0;
  localparam logic [31:0] NominalRatioReset  = 32'd8192;
  localparam logic [19:0] ErrorToleranceReset = 20'd100;
  localparam logic [31:0] SanityLimitReset   = 32'd1000000;

  typedef enum logic [1:0] {
    KindEstimate = 2'd0,
    KindSample   = 2'd1,
    KindRestart  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RegStartCounter   = 2'd0,
    RegNominalRatio   = 2'd1,
    RegErrorTolerance = 2'd2,
    RegSanityLimit    = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle   = 3'd0,
    StStart  = 3'd1,
    StDiv    = 3'd2,
    StErr    = 3'd3,
    StMag    = 3'd4,
    StCommit = 3'd5
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] tsc_now;
    logic [63:0] tsc_sample;
    logic [31:0] counter_low;
  } cer_in_t;

  typedef struct packed {
    logic [63:0]        estimate;
    logic [63:0]        counter_value;
    logic signed [63:0] est_error;
    logic [31:0]        ratio;
    logic               wrapped;
    logic               div_error;
    logic               fault;
  } cer_out_t;

  typedef struct packed {
    logic [63:0] start_counter;
    logic [31:0] nominal_ratio;
    logic [19:0] error_tolerance;
    logic [31:0] sanity_limit;
  } cer_cfg_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic div_start;
    logic est_load;
    logic err_load;
    logic mag_load;
    logic commit;
  } cer_cmd_t;

  typedef struct packed {
    logic is_restart;
    logic ratio_zero;
    logic div_done;
  } cer_status_t;

endpackage

// ===== rtl/core/counter_extend_and_rate_estimator.sv =====
// Top level: APB register file, controller and datapath of the counter extender.
// Depends on cer_pkg, cer_ctrl, cer_datapath (and cer_divider below it).
//
//  channel  signals                         accepted when
//  request  in_valid_i/in_ready_o/in_data_i  in_valid_i && in_ready_o
//  result   out_valid_o/out_ready_i/out_data_o  out_valid_o && out_ready_i
//  config   psel/penable/pwrite/paddr/pwdata  psel && penable && pwrite
//
// Estimate and sample requests pass through setup, the one-bit-a-cycle divider,
// its done cycle, two error steps and commit. Restart goes from setup straight
// to commit. Ratio zero skips the divider.
// A new request is taken while the previous result waits in the output register;
// commit holds until that register is free. Reset loads the register defaults.
module counter_extend_and_rate_estimator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cer_pkg::cer_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cer_pkg::cer_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import cer_pkg::*;

  cer_cfg_t    cfg_q;
  cer_cmd_t    cmd;
  cer_status_t status;
  logic        wr_en;
  cfg_reg_e    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = cfg_reg_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_counter   <= StartCounterReset;
      cfg_q.nominal_ratio   <= NominalRatioReset;
      cfg_q.error_tolerance <= ErrorToleranceReset;
      cfg_q.sanity_limit    <= SanityLimitReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegStartCounter:   cfg_q.start_counter   <= pwdata;
        RegNominalRatio:   cfg_q.nominal_ratio   <= pwdata[31:0];
        RegErrorTolerance: cfg_q.error_tolerance <= pwdata[19:0];
        RegSanityLimit:    cfg_q.sanity_limit    <= pwdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegStartCounter:   prdata = cfg_q.start_counter;
      RegNominalRatio:   prdata = {32'd0, cfg_q.nominal_ratio};
      RegErrorTolerance: prdata = {44'd0, cfg_q.error_tolerance};
      RegSanityLimit:    prdata = {32'd0, cfg_q.sanity_limit};
      default:           prdata = '0;
    endcase
  end

  cer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  cer_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/core/cer_divider.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on nothing outside this file.
module cer_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dsr_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[63]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    ge      = rem_sh >= {1'b0, dsr_q};
    rem_d   = ge ? rem_sub[31:0] : rem_sh[31:0];
    quo_d   = {quo_q[62:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == 6'd0) else $error("divider did not start");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && cnt_q != 6'd63 |=> busy_q && cnt_q == $past(cnt_q) + 6'd1)
    else $error("divider count skipped");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
`endif

endmodule

// ===== rtl/core/cer_datapath.sv =====
// Datapath: stored sample pair, ratio, fault flag, error arithmetic, result register.
// Depends on cer_pkg and cer_divider.
module cer_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cer_pkg::cer_cmd_t    cmd_i,
  output cer_pkg::cer_status_t status_o,
  input  cer_pkg::cer_cfg_t    cfg_i,
  input  cer_pkg::cer_in_t     in_data_i,
  output cer_pkg::cer_out_t    out_data_o
);
  import cer_pkg::*;

  cer_in_t     item_q;
  logic [63:0] last_stamp_q, last_stamp_d;
  logic [63:0] last_count_q, last_count_d;
  logic [31:0] tick_ratio_q, tick_ratio_d;
  logic        failed_q, failed_d;
  logic [63:0] est_q;
  logic        dz_q;
  logic [63:0] fresh_q;
  logic        wrap_q;
  logic [63:0] err_q;
  logic [63:0] mag_q;
  logic        neg_q;
  cer_out_t    out_q, out_d;
  logic [63:0] dividend;
  logic [63:0] delta;
  logic [63:0] quotient;
  logic        div_done;
  logic        wrap;
  logic [31:0] fresh_hi;
  logic        applied;
  logic        over_tol;
  logic        over_sanity;

  always_comb begin
    delta    = item_q.tsc_now - last_stamp_q;
    dividend = delta << SCALE_SHIFT;
    wrap     = item_q.counter_low < last_count_q[31:0];
    fresh_hi = last_count_q[63:32] + {31'd0, wrap};
  end

  cer_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (tick_ratio_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    applied      = (item_q.kind == KindSample) && !failed_q;
    over_tol     = mag_q > {44'd0, cfg_i.error_tolerance};
    over_sanity  = mag_q > {32'd0, cfg_i.sanity_limit};
    last_stamp_d = last_stamp_q;
    last_count_d = last_count_q;
    tick_ratio_d = tick_ratio_q;
    failed_d     = failed_q;
    out_d.estimate      = est_q;
    out_d.div_error     = dz_q;
    out_d.est_error     = '0;
    out_d.wrapped       = 1'b0;
    if (item_q.kind == KindRestart) begin
      last_stamp_d    = '0;
      last_count_d    = cfg_i.start_counter;
      tick_ratio_d    = cfg_i.nominal_ratio;
      failed_d        = 1'b0;
      out_d.estimate  = '0;
      out_d.div_error = 1'b0;
    end else if (applied) begin
      last_stamp_d = item_q.tsc_sample;
      last_count_d = fresh_q;
      if (over_tol) begin
        tick_ratio_d = neg_q ? tick_ratio_q - 32'd1 : tick_ratio_q + 32'd1;
      end
      failed_d        = failed_q | over_sanity;
      out_d.est_error = err_q;
      out_d.wrapped   = wrap_q;
    end
    out_d.counter_value = last_count_d;
    out_d.ratio         = tick_ratio_d;
    out_d.fault         = failed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stamp_q <= '0;
      last_count_q <= '0;
      tick_ratio_q <= NominalRatioReset;
      failed_q     <= 1'b0;
    end else if (cmd_i.commit) begin
      last_stamp_q <= last_stamp_d;
      last_count_q <= last_count_d;
      tick_ratio_q <= tick_ratio_d;
      failed_q     <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.prep) begin
      fresh_q <= {fresh_hi, item_q.counter_low};
      wrap_q  <= wrap;
      dz_q    <= tick_ratio_q == 32'd0;
    end
    if (cmd_i.est_load) begin
      est_q <= dz_q ? last_count_q : last_count_q + quotient;
    end
    if (cmd_i.err_load) begin
      err_q <= est_q - fresh_q;
    end
    if (cmd_i.mag_load) begin
      neg_q <= err_q[63];
      mag_q <= err_q[63] ? 64'd0 - err_q : err_q;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign status_o.is_restart = item_q.kind == KindRestart;
  assign status_o.ratio_zero = tick_ratio_q == 32'd0;
  assign status_o.div_done   = div_done;
  assign out_data_o          = out_q;

endmodule

// ===== rtl/core/cer_ctrl.sv =====
// Controller: sequences capture, division, error steps and commit of one request.
// Depends on cer_pkg.
module cer_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cer_pkg::cer_cmd_t    cmd_o,
  input  cer_pkg::cer_status_t status_i
);
  import cer_pkg::*;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  cer_cmd_t cmd;
  logic     slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    slot_free   = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = StStart;
        end
      end
      StStart: begin
        cmd.prep = 1'b1;
        if (status_i.is_restart) begin
          state_d = StCommit;
        end else if (status_i.ratio_zero) begin
          state_d = StDiv;
        end else begin
          cmd.div_start = 1'b1;
          state_d       = StDiv;
        end
      end
      StDiv: begin
        if (status_i.ratio_zero || status_i.div_done) begin
          cmd.est_load = 1'b1;
          state_d      = StErr;
        end
      end
      StErr: begin
        cmd.err_load = 1'b1;
        state_d      = StMag;
      end
      StMag: begin
        cmd.mag_load = 1'b1;
        state_d      = StCommit;
      end
      StCommit: begin
        if (slot_free) begin
          cmd.commit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

endmodule
